// ===== design/sync_length_deframer_core_defines.svh =====
// Assertion macros for the sync length deframer.
`ifndef SYNC_LENGTH_DEFRAMER_CORE_DEFINES_SVH
`define SYNC_LENGTH_DEFRAMER_CORE_DEFINES_SVH

// Implication checked at the same clock edge.
`define SLFD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slfd assertion failed");

// Implication checked at the following clock edge.
`define SLFD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slfd assertion failed");

`endif

// ===== design/slfd_pkg.sv =====
// Shared types and constants of the sync length deframer.
package slfd_pkg;

    localparam int unsigned SLFD_QUEUE_DEPTH = 4;
    localparam logic [15:0] SLFD_SYNC_RESET  = 16'h55AA;
    localparam int unsigned SLFD_LEN_W       = 9;

    typedef struct packed {
        logic       pair;
        logic       last;
        logic [7:0] hi;
        logic [7:0] lo;
    } slfd_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } slfd_q_status_t;

endpackage

// ===== design/slfd_if.sv =====
// Valid/ready channel interfaces of the sync length deframer.
interface slfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slfd_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_first;
    logic       frame_last;

    modport source (output valid, output frame_byte, output frame_first,
                    output frame_last, input ready);
    modport sink   (input valid, input frame_byte, input frame_first,
                    input frame_last, output ready);
endinterface

interface slfd_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] sync_word;

    modport source (output valid, output sync_word, input ready);
    modport sink   (input valid, input sync_word, output ready);
endinterface

// ===== design/sync_length_deframer_core.sv =====
// Top level of the sync length deframer.
//
//  channel | dir | beat payload                            | accepted when
//  rx      | in  | rx_byte[7:0]                            | valid && ready
//  frame   | out | frame_byte[7:0], frame_first, frame_last | valid && ready
//  cfg     | in  | sync_word[15:0]                         | valid && ready
//
// One rx beat per cycle while the command queue has room; frame beats leave
// from a registered output one per cycle unless frame ready stalls them, the
// sync pair as two beats. Commands pass a queue entry, then the output register.
// Reset returns the hunt to its start and sync_word to 0x55AA; no clearing pass.
// A stalled frame output fills the queue, then rx ready drops.
`include "sync_length_deframer_core_defines.svh"

module sync_length_deframer_core
    import slfd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = SLFD_QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    slfd_rx_if.sink      rx,
    slfd_frame_if.source frame,
    slfd_cfg_if.sink     cfg
);

    logic [15:0]    sync_word_reg;
    logic           push, pop;
    slfd_cmd_t      push_cmd, head;
    slfd_q_status_t q_status;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_word_reg <= SLFD_SYNC_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            sync_word_reg <= cfg.sync_word;
        end
    end

    slfd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .sync_word (sync_word_reg),
        .q_status  (q_status),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    slfd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    slfd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .frame    (frame)
    );

    `SLFD_ASSERT_SAME(a_first_not_last, frame.valid && frame.frame_first, !frame.frame_last)
    `SLFD_ASSERT_NEXT(a_pair_second,
                      frame.valid && frame.ready && frame.frame_first,
                      frame.valid && !frame.frame_first)
    `SLFD_ASSERT_SAME(a_pop_nonempty, pop, !q_status.empty)
    `SLFD_ASSERT_SAME(a_push_room, push, !q_status.full)

endmodule

// ===== design/slfd_front.sv =====
// Front end: sync hunt, length capture and frame byte classification.
module slfd_front
    import slfd_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    slfd_rx_if.sink        rx,
    input  logic [15:0]    sync_word,
    input  slfd_q_status_t q_status,
    output logic           push,
    output slfd_cmd_t      push_cmd
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_SYNC1,
        PH_LEN,
        PH_BODY
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic [SLFD_LEN_W-1:0]   bytes_left_reg, bytes_left_next;
    logic [7:0]              s1, s2, b;
    logic                    accept;

    assign s1       = sync_word[15:8];
    assign s2       = sync_word[7:0];
    assign b        = rx.rx_byte;
    assign rx.ready = !q_status.full;
    assign accept   = rx.valid && rx.ready;

    always_comb
    begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        push            = 1'b0;
        push_cmd        = '{pair: 1'b0, last: 1'b0, hi: s1, lo: b};
        if (accept)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (b == s1)
                    begin
                        phase_next = PH_SYNC1;
                    end
                end
                PH_SYNC1:
                begin
                    if (b == s2)
                    begin
                        push          = 1'b1;
                        push_cmd.pair = 1'b1;
                        push_cmd.lo   = s2;
                        phase_next    = PH_LEN;
                    end
                    else if (b != s1)
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_LEN:
                begin
                    push            = 1'b1;
                    bytes_left_next = {1'b0, b} + SLFD_LEN_W'(2);
                    phase_next      = PH_BODY;
                end
                PH_BODY:
                begin
                    push = 1'b1;
                    if (bytes_left_reg <= SLFD_LEN_W'(1))
                    begin
                        push_cmd.last   = 1'b1;
                        bytes_left_next = '0;
                        phase_next      = PH_HUNT;
                    end
                    else
                    begin
                        bytes_left_next = bytes_left_reg - SLFD_LEN_W'(1);
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            bytes_left_reg <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

endmodule

// ===== design/slfd_fifo.sv =====
// Short command queue between front end and back end.
module slfd_fifo
    import slfd_pkg::*;
#(
    parameter int unsigned DEPTH = SLFD_QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  slfd_cmd_t      push_cmd,
    input  logic           pop,
    output slfd_cmd_t      head,
    output slfd_q_status_t status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    slfd_cmd_t         mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== design/slfd_back.sv =====
// Back end: expands queued commands into output beats.
module slfd_back
    import slfd_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  slfd_cmd_t      head,
    input  slfd_q_status_t q_status,
    output logic           pop,
    slfd_frame_if.source   frame
);

    logic       out_valid_reg, out_valid_next;
    logic       pending_reg, pending_next;
    logic [7:0] byte_reg, byte_next;
    logic       first_reg, first_next;
    logic       last_reg, last_next;
    logic [7:0] lo_reg, lo_next;
    logic       load_ok;

    assign load_ok = !out_valid_reg || frame.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        pending_next   = pending_reg;
        byte_next      = byte_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        lo_next        = lo_reg;
        pop            = 1'b0;
        if (load_ok)
        begin
            if (pending_reg)
            begin
                out_valid_next = 1'b1;
                byte_next      = lo_reg;
                first_next     = 1'b0;
                last_next      = 1'b0;
                pending_next   = 1'b0;
            end
            else if (!q_status.empty)
            begin
                pop            = 1'b1;
                out_valid_next = 1'b1;
                if (head.pair)
                begin
                    byte_next    = head.hi;
                    first_next   = 1'b1;
                    last_next    = 1'b0;
                    lo_next      = head.lo;
                    pending_next = 1'b1;
                end
                else
                begin
                    byte_next  = head.lo;
                    first_next = 1'b0;
                    last_next  = head.last;
                end
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pending_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pending_reg   <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        first_reg <= first_next;
        last_reg  <= last_next;
        lo_reg    <= lo_next;
    end

    assign frame.valid       = out_valid_reg;
    assign frame.frame_byte  = byte_reg;
    assign frame.frame_first = first_reg;
    assign frame.frame_last  = last_reg;

endmodule
